// ----- rtl/core/rvd_pkg.sv -----
// Shared types and constants for the RV32I instruction decoder pipeline.
// No dependencies; every other file in rtl/core imports this package.
package rvd_pkg;

  // Major opcodes, bits 6..0 of the instruction word.
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // Funct7 codes that select between the paired ALU operations.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Whole words that name the environment calls.
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  // Base mnemonics; the encoding is the value seen on the mnemonic port.
  typedef enum logic [5:0] {
    MN_ILLEGAL = 6'd0,
    MN_LUI     = 6'd1,
    MN_AUIPC   = 6'd2,
    MN_JAL     = 6'd3,
    MN_JALR    = 6'd4,
    MN_BEQ     = 6'd5,
    MN_BNE     = 6'd6,
    MN_BLT     = 6'd7,
    MN_BGE     = 6'd8,
    MN_BLTU    = 6'd9,
    MN_BGEU    = 6'd10,
    MN_SB      = 6'd11,
    MN_SH      = 6'd12,
    MN_SW      = 6'd13,
    MN_ADD     = 6'd14,
    MN_SUB     = 6'd15,
    MN_SLL     = 6'd16,
    MN_SLT     = 6'd17,
    MN_SLTU    = 6'd18,
    MN_XOR     = 6'd19,
    MN_SRL     = 6'd20,
    MN_SRA     = 6'd21,
    MN_OR      = 6'd22,
    MN_AND     = 6'd23,
    MN_LB      = 6'd24,
    MN_LH      = 6'd25,
    MN_LW      = 6'd26,
    MN_LBU     = 6'd27,
    MN_LHU     = 6'd28,
    MN_ADDI    = 6'd29,
    MN_SLTI    = 6'd30,
    MN_SLTIU   = 6'd31,
    MN_XORI    = 6'd32,
    MN_ORI     = 6'd33,
    MN_ANDI    = 6'd34,
    MN_SLLI    = 6'd35,
    MN_SRLI    = 6'd36,
    MN_SRAI    = 6'd37,
    MN_CSRRW   = 6'd38,
    MN_CSRRS   = 6'd39,
    MN_CSRRC   = 6'd40,
    MN_CSRRWI  = 6'd41,
    MN_CSRRSI  = 6'd42,
    MN_CSRRCI  = 6'd43,
    MN_ECALL   = 6'd44,
    MN_EBREAK  = 6'd45
  } mnem_e;

  // Decoded item handed from the decode stage to the output stage.
  typedef struct packed {
    mnem_e              mnemonic;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [20:0] imm;
    logic [11:0]        csr;
    logic [31:0]        addr;
    logic               use_target;
  } dec_t;

endpackage

// ----- rtl/core/rv32i_instruction_decoder.sv -----
// RV32I instruction decoder, three register stages: input, decode, output.
// An accepted item passes through the input, decode and output registers in that
// order before it shows on the outputs.
// Throughput is one item per cycle; the whole pipeline holds when the output stalls.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload is not reset.
// Top level; depends on rvd_pkg, rvd_decode and rvd_output.
module rv32i_instruction_decoder
  import rvd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instruction_word_i,
  input  logic [31:0]        instruction_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         mnemonic_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [20:0] immediate_o,
  output logic [31:0]        target_address_o,
  output logic [11:0]        csr_number_o
);

  logic        advance;
  logic        in_valid_q;
  logic [31:0] word_q;
  logic [31:0] addr_q;
  logic        dec_valid;
  dec_t        dec;

  // The pipeline moves whenever the output slot is empty or being taken.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_q <= instruction_word_i;
      addr_q <= instruction_address_i;
    end
  end

  rvd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_q),
    .word_i  (word_q),
    .addr_i  (addr_q),
    .valid_o (dec_valid),
    .dec_o   (dec)
  );

  rvd_output u_output (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .valid_i          (dec_valid),
    .dec_i            (dec),
    .valid_o          (out_valid_o),
    .mnemonic_o       (mnemonic_o),
    .dest_reg_o       (dest_reg_o),
    .src1_reg_o       (src1_reg_o),
    .src2_reg_o       (src2_reg_o),
    .immediate_o      (immediate_o),
    .target_address_o (target_address_o),
    .csr_number_o     (csr_number_o)
  );

  // An accepted item reaches the input stage register on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q && word_q == $past(instruction_word_i))
    else $error("top: accepted item did not enter the pipeline");

  // Decode copies the rd and rs2 fields of the word untouched into its stage record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q |=> dec.rd == $past(word_q[11:7]) && dec.rs2 == $past(word_q[24:20]))
    else $error("top: register field corrupted in decode");

  // A result that is not taken stays on the outputs unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(mnemonic_o) && $stable(immediate_o) && $stable(target_address_o))
    else $error("top: result changed while the output was stalled");

endmodule

// ----- rtl/core/rvd_decode.sv -----
// Decode stage: classifies the instruction word and extracts its fields.
// Depends on rvd_pkg for opcodes, mnemonics and the dec_t stage record.
module rvd_decode
  import rvd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] word_i,
  input  logic [31:0] addr_i,
  output logic        valid_o,
  output dec_t        dec_o
);

  logic [2:0]         f3;
  logic [6:0]         f7;
  logic signed [20:0] imm_i_fmt;
  logic signed [20:0] imm_s_fmt;
  logic signed [20:0] imm_b_fmt;
  logic signed [20:0] imm_j_fmt;
  logic signed [20:0] imm_u_fmt;
  logic signed [20:0] imm_shamt;
  dec_t               dec_d;
  dec_t               dec_q;
  logic               valid_q;

  assign f3 = word_i[14:12];
  assign f7 = word_i[31:25];

  // Immediates for each format: I, S and B sign extended to the 21-bit result field, J filling it, U zero extended.
  assign imm_i_fmt = {{9{word_i[31]}}, word_i[31:20]};
  assign imm_s_fmt = {{9{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign imm_b_fmt = {{8{word_i[31]}}, word_i[31], word_i[7], word_i[30:25],
                      word_i[11:8], 1'b0};
  assign imm_j_fmt = {word_i[31], word_i[19:12], word_i[20], word_i[30:21], 1'b0};
  assign imm_u_fmt = {1'b0, word_i[31:12]};

  // Shift amount as a truncating remainder by 32 of the signed I value:
  // a negative value with nonzero low bits keeps its sign.
  always_comb begin
    if (word_i[31] && (word_i[24:20] != 5'd0)) begin
      imm_shamt = {16'hffff, word_i[24:20]};
    end else begin
      imm_shamt = {16'h0000, word_i[24:20]};
    end
  end

  // Mnemonic classification and immediate selection.
  always_comb begin
    dec_d            = '0;
    dec_d.mnemonic   = MN_ILLEGAL;
    dec_d.rd         = word_i[11:7];
    dec_d.rs1        = word_i[19:15];
    dec_d.rs2        = word_i[24:20];
    dec_d.addr       = addr_i;
    dec_d.use_target = 1'b0;
    unique case (word_i[6:0])
      OPC_LUI: begin
        dec_d.mnemonic = MN_LUI;
        dec_d.imm      = imm_u_fmt;
      end
      OPC_AUIPC: begin
        dec_d.mnemonic = MN_AUIPC;
        dec_d.imm      = imm_u_fmt;
      end
      OPC_JAL: begin
        dec_d.mnemonic   = MN_JAL;
        dec_d.imm        = imm_j_fmt;
        dec_d.use_target = 1'b1;
      end
      OPC_JALR: begin
        dec_d.mnemonic = MN_JALR;
        dec_d.imm      = imm_i_fmt;
      end
      OPC_BRANCH: begin
        if (f3 != 3'd2 && f3 != 3'd3) begin
          dec_d.imm        = imm_b_fmt;
          dec_d.use_target = 1'b1;
          unique case (f3)
            3'd0:    dec_d.mnemonic = MN_BEQ;
            3'd1:    dec_d.mnemonic = MN_BNE;
            3'd4:    dec_d.mnemonic = MN_BLT;
            3'd5:    dec_d.mnemonic = MN_BGE;
            3'd6:    dec_d.mnemonic = MN_BLTU;
            default: dec_d.mnemonic = MN_BGEU;
          endcase
        end
      end
      OPC_STORE: begin
        if (f3 < 3'd3) begin
          dec_d.imm = imm_s_fmt;
          unique case (f3)
            3'd0:    dec_d.mnemonic = MN_SB;
            3'd1:    dec_d.mnemonic = MN_SH;
            default: dec_d.mnemonic = MN_SW;
          endcase
        end
      end
      OPC_OP: begin
        unique case (f3)
          3'd0: begin
            if (f7 == F7_BASE)     dec_d.mnemonic = MN_ADD;
            else if (f7 == F7_ALT) dec_d.mnemonic = MN_SUB;
          end
          3'd1: dec_d.mnemonic = MN_SLL;
          3'd2: dec_d.mnemonic = MN_SLT;
          3'd3: dec_d.mnemonic = MN_SLTU;
          3'd4: dec_d.mnemonic = MN_XOR;
          3'd5: begin
            if (f7 == F7_BASE)     dec_d.mnemonic = MN_SRL;
            else if (f7 == F7_ALT) dec_d.mnemonic = MN_SRA;
          end
          3'd6:    dec_d.mnemonic = MN_OR;
          default: dec_d.mnemonic = MN_AND;
        endcase
      end
      OPC_LOAD: begin
        unique case (f3)
          3'd0:    dec_d.mnemonic = MN_LB;
          3'd1:    dec_d.mnemonic = MN_LH;
          3'd2:    dec_d.mnemonic = MN_LW;
          3'd4:    dec_d.mnemonic = MN_LBU;
          3'd5:    dec_d.mnemonic = MN_LHU;
          default: dec_d.mnemonic = MN_ILLEGAL;
        endcase
        if (dec_d.mnemonic != MN_ILLEGAL) begin
          dec_d.imm = imm_i_fmt;
        end
      end
      OPC_OP_IMM: begin
        unique case (f3)
          3'd0: begin dec_d.mnemonic = MN_ADDI;  dec_d.imm = imm_i_fmt; end
          3'd2: begin dec_d.mnemonic = MN_SLTI;  dec_d.imm = imm_i_fmt; end
          3'd3: begin dec_d.mnemonic = MN_SLTIU; dec_d.imm = imm_i_fmt; end
          3'd4: begin dec_d.mnemonic = MN_XORI;  dec_d.imm = imm_i_fmt; end
          3'd6: begin dec_d.mnemonic = MN_ORI;   dec_d.imm = imm_i_fmt; end
          3'd7: begin dec_d.mnemonic = MN_ANDI;  dec_d.imm = imm_i_fmt; end
          3'd1: begin dec_d.mnemonic = MN_SLLI;  dec_d.imm = imm_shamt; end
          default: begin
            if (f7 == F7_BASE) begin
              dec_d.mnemonic = MN_SRLI;
              dec_d.imm      = imm_shamt;
            end else if (f7 == F7_ALT) begin
              dec_d.mnemonic = MN_SRAI;
              dec_d.imm      = imm_shamt;
            end
          end
        endcase
      end
      OPC_SYSTEM: begin
        unique case (f3)
          3'd1: begin dec_d.mnemonic = MN_CSRRW;  dec_d.csr = word_i[31:20]; end
          3'd2: begin dec_d.mnemonic = MN_CSRRS;  dec_d.csr = word_i[31:20]; end
          3'd3: begin dec_d.mnemonic = MN_CSRRC;  dec_d.csr = word_i[31:20]; end
          3'd5: begin dec_d.mnemonic = MN_CSRRWI; dec_d.csr = word_i[31:20]; end
          3'd6: begin dec_d.mnemonic = MN_CSRRSI; dec_d.csr = word_i[31:20]; end
          3'd7: begin dec_d.mnemonic = MN_CSRRCI; dec_d.csr = word_i[31:20]; end
          default: begin
            if (word_i == WORD_ECALL)       dec_d.mnemonic = MN_ECALL;
            else if (word_i == WORD_EBREAK) dec_d.mnemonic = MN_EBREAK;
          end
        endcase
      end
      default: dec_d.mnemonic = MN_ILLEGAL;
    endcase
  end

  // Stage register; the valid bit travels with the decoded item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

  // A target is only requested by jumps and branches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && dec_q.use_target |->
      (dec_q.mnemonic == MN_JAL || dec_q.mnemonic == MN_BEQ || dec_q.mnemonic == MN_BNE ||
       dec_q.mnemonic == MN_BLT || dec_q.mnemonic == MN_BGE || dec_q.mnemonic == MN_BLTU ||
       dec_q.mnemonic == MN_BGEU))
    else $error("decode: target requested for a non-control-flow item");

  // Illegal words carry no immediate and no CSR number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && dec_q.mnemonic == MN_ILLEGAL |->
      dec_q.imm == '0 && dec_q.csr == '0 && !dec_q.use_target)
    else $error("decode: illegal item carries payload");

  // A held stage keeps its item while the pipeline is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_q) && (!valid_q || $stable(dec_q)))
    else $error("decode: stage changed during a stall");

endmodule

// ----- rtl/core/rvd_output.sv -----
// Output stage: adds the jump or branch offset to the address and holds the result item.
// Depends on rvd_pkg for the dec_t stage record and the mnemonic codes.
module rvd_output
  import rvd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  dec_t               dec_i,
  output logic               valid_o,
  output logic [5:0]         mnemonic_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [20:0] immediate_o,
  output logic [31:0]        target_address_o,
  output logic [11:0]        csr_number_o
);

  logic               valid_q;
  mnem_e              mnem_q;
  logic [4:0]         rd_q;
  logic [4:0]         rs1_q;
  logic [4:0]         rs2_q;
  logic signed [20:0] imm_q;
  logic [11:0]        csr_q;
  logic [31:0]        target_d;
  logic [31:0]        target_q;

  // Target is the address plus the sign-extended offset, wrapping at 2^32, for items that request it; else zero.
  always_comb begin
    if (dec_i.use_target) begin
      target_d = dec_i.addr + {{11{dec_i.imm[20]}}, dec_i.imm};
    end else begin
      target_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mnem_q   <= dec_i.mnemonic;
      rd_q     <= dec_i.rd;
      rs1_q    <= dec_i.rs1;
      rs2_q    <= dec_i.rs2;
      imm_q    <= dec_i.imm;
      csr_q    <= dec_i.csr;
      target_q <= target_d;
    end
  end

  assign valid_o          = valid_q;
  assign mnemonic_o       = mnem_q;
  assign dest_reg_o       = rd_q;
  assign src1_reg_o       = rs1_q;
  assign src2_reg_o       = rs2_q;
  assign immediate_o      = imm_q;
  assign target_address_o = target_q;
  assign csr_number_o     = csr_q;

  // A nonzero CSR number only comes with a CSR mnemonic.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && csr_q != '0 |->
      (mnem_q == MN_CSRRW || mnem_q == MN_CSRRS || mnem_q == MN_CSRRC ||
       mnem_q == MN_CSRRWI || mnem_q == MN_CSRRSI || mnem_q == MN_CSRRCI))
    else $error("output: CSR number on a non-CSR item");

  // A jal target sits at an even offset from the address of the jump.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && dec_i.mnemonic == MN_JAL |=>
      target_q[0] == $past(dec_i.addr[0]))
    else $error("output: jal target parity mismatch");

  // A nonzero target only comes with a jump or a branch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && target_q != '0 |->
      (mnem_q == MN_JAL || (mnem_q >= MN_BEQ && mnem_q <= MN_BGEU)))
    else $error("output: target on an item that is not a jump or branch");

endmodule
